// ===== hw/rtl/crv_pkg.sv =====
// ============================================================================
// crv_pkg: shared types, constants and functions of the CORDIC block
// ----------------------------------------------------------------------------
// Datapath widths, the pipeline payload structure, the post-correction codes
// and the constant functions that derive the angle constants at elaboration.
// ============================================================================
package crv_pkg;

  // Width of the external Q3.28 fields.
  localparam int IO_W = 31;
  // Internal datapath width; holds the grown vector and every angle sum.
  localparam int DW = 34;
  // Width of the final correction arithmetic, before saturation.
  localparam int FW = 36;
  // Low part of the split gain multiply.
  localparam int GAIN_LO_W = 17;

  // pi with 60 fraction bits.
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  // round(0.6072529350 * 2^31).
  localparam logic [30:0] GAIN_Q31 = 31'd1304065748;

  localparam logic signed [FW-1:0] OUT_MAX = 36'sd1073741823;
  localparam logic signed [FW-1:0] OUT_MIN = -36'sd1073741824;

  // Correction applied after the gain stage.
  typedef enum logic [1:0] {
    FIX_NONE     = 2'd0,
    FIX_NEGATE   = 2'd1,
    FIX_ADD_HALF = 2'd2,
    FIX_SUB_HALF = 2'd3
  } fix_e;

  // State that travels along the row of micro-rotation cells.
  typedef struct packed {
    logic                   rotate;
    fix_e                   fix;
    logic signed [DW-1:0]   x;
    logic signed [DW-1:0]   y;
    logic signed [DW-1:0]   z;
    logic signed [DW-1:0]   theta;
  } stage_t;

  // Gain-corrected result ahead of the final correction.
  typedef struct packed {
    fix_e                   fix;
    logic signed [DW-1:0]   x;
    logic signed [DW-1:0]   y;
    logic signed [DW-1:0]   z;
  } post_t;

  // Rounds a Q.60 constant to nearest at the given number of fraction bits.
  function automatic logic [63:0] q60_round(input logic [63:0] v, input int unsigned frac);
    int unsigned sh;
    sh = 60 - frac;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // Numerator 2^(60 - i*(2k+1)) of one arctangent series term, or zero once
  // the term falls below the Q.60 resolution.
  function automatic logic [63:0] atan_num(input int unsigned i, input int unsigned k);
    int unsigned p;
    p = i * (2 * k + 1);
    if (p > 60) begin
      return 64'd0;
    end
    return 64'd1 << (60 - p);
  endfunction

  // Clamps a correction result to the 31-bit output range.
  function automatic logic signed [IO_W-1:0] sat_out(input logic signed [FW-1:0] v);
    if (v > OUT_MAX) begin
      return OUT_MAX[IO_W-1:0];
    end
    if (v < OUT_MIN) begin
      return OUT_MIN[IO_W-1:0];
    end
    return v[IO_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/crv_in_if.sv =====
// ============================================================================
// crv_in_if: request channel of the CORDIC block
// ----------------------------------------------------------------------------
// Valid/ready channel carrying the operation and the input vector and angle.
// ============================================================================
interface crv_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic signed [crv_pkg::IO_W-1:0]  vec_x;
  logic signed [crv_pkg::IO_W-1:0]  vec_y;
  logic signed [crv_pkg::IO_W-1:0]  angle_in;

  modport source (output valid, output operation, output vec_x, output vec_y,
                  output angle_in, input ready);
  modport sink   (input valid, input operation, input vec_x, input vec_y,
                  input angle_in, output ready);
endinterface

// ===== hw/rtl/crv_out_if.sv =====
// ============================================================================
// crv_out_if: result channel of the CORDIC block
// ----------------------------------------------------------------------------
// Valid/ready channel carrying the rotated vector and the angle.
// ============================================================================
interface crv_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [crv_pkg::IO_W-1:0]  cos_out;
  logic signed [crv_pkg::IO_W-1:0]  sin_out;
  logic signed [crv_pkg::IO_W-1:0]  angle_out;

  modport source (output valid, output cos_out, output sin_out, output angle_out,
                  input ready);
  modport sink   (input valid, input cos_out, input sin_out, input angle_out,
                  output ready);
endinterface

// ===== hw/rtl/crv_pre.sv =====
// ============================================================================
// crv_pre: quadrant folding stage
// ----------------------------------------------------------------------------
// Folds the rotation angle into [-pi/2, pi/2] or pre-rotates a vector with
// negative x by 90 degrees, and registers the start state of the cell row.
// ============================================================================
module crv_pre #(
  parameter int FRAC_BITS = 28
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic                             operation_i,
  input  logic signed [crv_pkg::IO_W-1:0]  vec_x_i,
  input  logic signed [crv_pkg::IO_W-1:0]  vec_y_i,
  input  logic signed [crv_pkg::IO_W-1:0]  angle_i,
  output logic                             valid_o,
  output crv_pkg::stage_t                  data_o
);

  localparam int W  = crv_pkg::DW;
  localparam int EW = crv_pkg::DW - crv_pkg::IO_W;
  localparam logic signed [W-1:0] PI      =
    W'(crv_pkg::q60_round(crv_pkg::PI_Q60, FRAC_BITS));
  localparam logic signed [W-1:0] HALF_PI =
    W'(crv_pkg::q60_round(crv_pkg::PI_Q60 >> 1, FRAC_BITS));

  logic signed [W-1:0] x, y, th;
  crv_pkg::stage_t     data_d, data_q;
  logic                valid_q;

  assign x  = $signed({{EW{vec_x_i[crv_pkg::IO_W-1]}}, vec_x_i});
  assign y  = $signed({{EW{vec_y_i[crv_pkg::IO_W-1]}}, vec_y_i});
  assign th = $signed({{EW{angle_i[crv_pkg::IO_W-1]}}, angle_i});

  always_comb begin
    data_d.rotate = operation_i;
    data_d.fix    = crv_pkg::FIX_NONE;
    data_d.x      = x;
    data_d.y      = y;
    data_d.z      = '0;
    data_d.theta  = th;
    if (operation_i) begin
      if (th < -HALF_PI || th > HALF_PI) begin
        data_d.theta = th[W-1] ? th + PI : th - PI;
        data_d.fix   = crv_pkg::FIX_NEGATE;
      end
    end else if (x[W-1]) begin
      if (!y[W-1]) begin
        data_d.x   = y;
        data_d.y   = -x;
        data_d.fix = crv_pkg::FIX_ADD_HALF;
      end else begin
        data_d.x   = -y;
        data_d.y   = x;
        data_d.fix = crv_pkg::FIX_SUB_HALF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/crv_cell.sv =====
// ============================================================================
// crv_cell: one CORDIC micro-rotation
// ----------------------------------------------------------------------------
// Shifts by its stage index, adds or subtracts the stage's arctangent and
// hands the registered state to the next cell.
// ============================================================================
module crv_cell #(
  parameter int STAGE     = 0,
  parameter int FRAC_BITS = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  crv_pkg::stage_t  data_i,
  output logic             valid_o,
  output crv_pkg::stage_t  data_o
);

  localparam int W = crv_pkg::DW;

  // Arctangent of 2^-STAGE in Q.60 from its power series.
  localparam logic [63:0] ATAN_Q60 = (STAGE == 0) ? (crv_pkg::PI_Q60 >> 2) :
      crv_pkg::atan_num(STAGE, 0) / 64'd1   - crv_pkg::atan_num(STAGE, 1) / 64'd3
    + crv_pkg::atan_num(STAGE, 2) / 64'd5   - crv_pkg::atan_num(STAGE, 3) / 64'd7
    + crv_pkg::atan_num(STAGE, 4) / 64'd9   - crv_pkg::atan_num(STAGE, 5) / 64'd11
    + crv_pkg::atan_num(STAGE, 6) / 64'd13  - crv_pkg::atan_num(STAGE, 7) / 64'd15
    + crv_pkg::atan_num(STAGE, 8) / 64'd17  - crv_pkg::atan_num(STAGE, 9) / 64'd19
    + crv_pkg::atan_num(STAGE, 10) / 64'd21 - crv_pkg::atan_num(STAGE, 11) / 64'd23
    + crv_pkg::atan_num(STAGE, 12) / 64'd25 - crv_pkg::atan_num(STAGE, 13) / 64'd27
    + crv_pkg::atan_num(STAGE, 14) / 64'd29 - crv_pkg::atan_num(STAGE, 15) / 64'd31
    + crv_pkg::atan_num(STAGE, 16) / 64'd33 - crv_pkg::atan_num(STAGE, 17) / 64'd35
    + crv_pkg::atan_num(STAGE, 18) / 64'd37 - crv_pkg::atan_num(STAGE, 19) / 64'd39
    + crv_pkg::atan_num(STAGE, 20) / 64'd41 - crv_pkg::atan_num(STAGE, 21) / 64'd43
    + crv_pkg::atan_num(STAGE, 22) / 64'd45 - crv_pkg::atan_num(STAGE, 23) / 64'd47
    + crv_pkg::atan_num(STAGE, 24) / 64'd49 - crv_pkg::atan_num(STAGE, 25) / 64'd51
    + crv_pkg::atan_num(STAGE, 26) / 64'd53 - crv_pkg::atan_num(STAGE, 27) / 64'd55
    + crv_pkg::atan_num(STAGE, 28) / 64'd57 - crv_pkg::atan_num(STAGE, 29) / 64'd59;

  localparam logic signed [W-1:0] ATAN = W'(crv_pkg::q60_round(ATAN_Q60, FRAC_BITS));

  logic signed [W-1:0] x, y, z, theta, dx, dy;
  logic                clockwise_n;
  crv_pkg::stage_t     data_d, data_q;
  logic                valid_q;

  assign x     = data_i.x;
  assign y     = data_i.y;
  assign z     = data_i.z;
  assign theta = data_i.theta;
  assign dx    = y >>> STAGE;
  assign dy    = x >>> STAGE;

  // Rotation mode steers z toward theta; vectoring mode drives y to zero.
  assign clockwise_n = data_i.rotate ? (z < theta) : y[W-1];

  always_comb begin
    data_d = data_i;
    if (clockwise_n) begin
      data_d.x = x - dx;
      data_d.y = y + dy;
      data_d.z = z + ATAN;
    end else begin
      data_d.x = x + dx;
      data_d.y = y - dy;
      data_d.z = z - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/crv_post.sv =====
// ============================================================================
// crv_post: CORDIC gain correction
// ----------------------------------------------------------------------------
// Multiplies x and y by the inverse CORDIC gain in two stages: split partial
// products first, then the rounded recombination.
// ============================================================================
module crv_post (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  crv_pkg::stage_t  data_i,
  output logic             valid_o,
  output crv_pkg::post_t   data_o
);

  localparam int W   = crv_pkg::DW;
  localparam int LW  = crv_pkg::GAIN_LO_W;
  localparam int HW  = W - LW;
  localparam int PLW = LW + 31;
  localparam int PHW = HW + 32;
  localparam int TW  = W + 33;

  logic signed [W-1:0]   lane_in [2];
  logic [PLW-1:0]        plo_d [2];
  logic [PLW-1:0]        plo_q [2];
  logic signed [PHW-1:0] phi_d [2];
  logic signed [PHW-1:0] phi_q [2];
  logic signed [TW-1:0]  tot [2];
  logic signed [TW-1:0]  res [2];

  crv_pkg::fix_e         fix_a_q;
  logic signed [W-1:0]   z_a_q;
  logic                  valid_a_q;
  crv_pkg::post_t        data_b_d, data_b_q;
  logic                  valid_b_q;

  assign lane_in[0] = data_i.x;
  assign lane_in[1] = data_i.y;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [LW-1:0]        lo;
    logic signed [HW-1:0] hi;

    assign lo       = lane_in[l][LW-1:0];
    assign hi       = lane_in[l][W-1:LW];
    assign plo_d[l] = lo * crv_pkg::GAIN_Q31;
    assign phi_d[l] = hi * $signed({1'b0, crv_pkg::GAIN_Q31});

    // v * gain + 2^30, then an arithmetic shift by 31.
    assign tot[l] = (TW'(phi_q[l]) <<< LW) + $signed(TW'(plo_q[l]))
                  + (TW'(1) <<< 30);
    assign res[l] = tot[l] >>> 31;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        plo_q[l] <= plo_d[l];
        phi_q[l] <= phi_d[l];
      end
    end
  end

  always_comb begin
    data_b_d.fix = fix_a_q;
    data_b_d.z   = z_a_q;
    data_b_d.x   = res[0][W-1:0];
    data_b_d.y   = res[1][W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fix_a_q  <= data_i.fix;
      z_a_q    <= data_i.z;
      data_b_q <= data_b_d;
    end
  end

  assign valid_o = valid_b_q;
  assign data_o  = data_b_q;

endmodule

// ===== hw/rtl/cordic_rotate_vector.sv =====
// ============================================================================
// cordic_rotate_vector: pipelined circular CORDIC, rotation and vectoring
// ----------------------------------------------------------------------------
// Computes cos/sin rotation or magnitude/arctangent on signed Q3.28 values
// through a row of shift-add micro-rotation cells and a gain correction.
// ============================================================================
// The block takes one transaction per clock cycle while req_i.ready is high and
// returns exactly one result transaction for each, in order. Its stages are
// one folding stage, one cell per micro-rotation, two stages for the
// inverse-gain multiply and the output register. The row of cells runs as a
// single pipeline that moves whenever the output register can take the item
// leaving the gain stage; with the output register full and not drained, the
// pipeline keeps accepting until an item reaches the end of the gain stage,
// so req_i.ready falls only in that case. With operation = 1 the input vector
// is rotated by angle_in (angles outside [-pi/2, pi/2] are folded by pi and
// the outputs negated); with operation = 0 the vector is rotated onto the
// x axis, cos_out returns the magnitude, sin_out the residual and angle_out
// atan2(vec_y, vec_x). Outputs saturate to the 31-bit signed range. The block
// holds no configuration and needs no setup after reset.
module cordic_rotate_vector #(
  parameter int ITERATIONS = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crv_in_if.sink     req_i,
  crv_out_if.source  rsp_o
);

  localparam int FW = crv_pkg::FW;
  localparam logic signed [FW-1:0] HALF_PI =
    FW'(crv_pkg::q60_round(crv_pkg::PI_Q60 >> 1, FRAC_BITS));

  // Pipeline advance: everything behind the output register moves unless
  // the last gain stage holds an item that the output register cannot take.
  logic en;
  logic stall;

  logic            chain_valid [ITERATIONS+1];
  crv_pkg::stage_t chain_data  [ITERATIONS+1];

  logic            post_valid;
  crv_pkg::post_t  post_data;

  // Final correction and saturation.
  logic signed [FW-1:0] fx, fy, fz;
  logic signed [crv_pkg::IO_W-1:0] cos_d, sin_d, ang_d;
  logic signed [crv_pkg::IO_W-1:0] cos_q, sin_q, ang_q;
  logic out_valid_q;
  logic out_load;

  assign stall       = post_valid && out_valid_q && !rsp_o.ready;
  assign en          = !stall;
  assign req_i.ready = en;

  crv_pre #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (req_i.valid),
    .operation_i (req_i.operation),
    .vec_x_i     (req_i.vec_x),
    .vec_y_i     (req_i.vec_y),
    .angle_i     (req_i.angle_in),
    .valid_o     (chain_valid[0]),
    .data_o      (chain_data[0])
  );

  // One cell per micro-rotation; cell i shifts by i.
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    crv_cell #(
      .STAGE     (i),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  crv_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[ITERATIONS]),
    .data_i  (chain_data[ITERATIONS]),
    .valid_o (post_valid),
    .data_o  (post_data)
  );

  // The accumulated angle is reported negated; the quadrant fixes of the
  // folding stage are undone here.
  always_comb begin
    fx = FW'(post_data.x);
    fy = FW'(post_data.y);
    fz = -FW'(post_data.z);
    case (post_data.fix)
      crv_pkg::FIX_NONE: begin
      end
      crv_pkg::FIX_NEGATE: begin
        fx = -FW'(post_data.x);
        fy = -FW'(post_data.y);
      end
      crv_pkg::FIX_ADD_HALF: begin
        fz = -FW'(post_data.z) + HALF_PI;
      end
      crv_pkg::FIX_SUB_HALF: begin
        fz = -FW'(post_data.z) - HALF_PI;
      end
      default: begin
      end
    endcase
  end

  assign cos_d = crv_pkg::sat_out(fx);
  assign sin_d = crv_pkg::sat_out(fy);
  assign ang_d = crv_pkg::sat_out(fz);

  // The output register loads whenever it is empty or being drained.
  assign out_load = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= post_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
      ang_q <= ang_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.cos_out   = cos_q;
  assign rsp_o.sin_out   = sin_q;
  assign rsp_o.angle_out = ang_q;

`ifndef NO_ASSERTIONS
  // Input back-pressure only ever comes from a blocked result.
  a_ready_only_on_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (rsp_o.valid && !rsp_o.ready))
    else $error("request stalled without a blocked result");

  // An accepted transaction always enters the folding stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> chain_valid[0])
    else $error("accepted transaction lost at the folding stage");

  // A result only appears after the gain stage held a valid item.
  a_result_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(post_valid))
    else $error("result produced without a pipeline item");

  // While stalled, the gain stage must keep its item.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> post_valid)
    else $error("gain stage dropped an item during a stall");
`endif

endmodule
